// ----- rtl/lzs_pkg.sv -----
package lzs_pkg;

    localparam int OFF_W = 11;
    localparam int LEN_W = 5;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = 2;

    localparam logic [2:0] CMD_MARK = 3'd0;
    localparam logic [2:0] CMD_LIT  = 3'd1;
    localparam logic [2:0] CMD_COPY = 3'd2;
    localparam logic [2:0] CMD_END  = 3'd3;
    localparam logic [2:0] CMD_ERR  = 3'd4;

    // restart: clear history pointer before this command
    // eob: last command of its input item
    typedef struct packed {
        logic [2:0]       kind;
        logic             restart;
        logic             eob;
        logic [OFF_W-1:0] data;
        logic [LEN_W-1:0] len;
    } t_cmd;

endpackage

// ----- rtl/lzs_front.sv -----
module lzs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_new_stream,
    input  logic [7:0]    i_compressed_byte,
    output logic          o_push,
    output lzs_pkg::t_cmd o_cmd,
    input  logic          i_full
);

    localparam logic [2:0] PH_FLAG  = 3'd0;
    localparam logic [2:0] PH_TYPE  = 3'd1;
    localparam logic [2:0] PH_LIT   = 3'd2;
    localparam logic [2:0] PH_SHORT = 3'd3;
    localparam logic [2:0] PH_LONG  = 3'd4;
    localparam logic [2:0] PH_LEN_A = 3'd5;
    localparam logic [2:0] PH_LEN_B = 3'd6;
    localparam logic [2:0] PH_NIB   = 3'd7;

    logic        r_busy;
    logic [7:0]  r_sh;
    logic [2:0]  r_bitn;
    logic        r_restart;
    logic [2:0]  r_phase, n_phase;
    logic [10:0] r_field, n_field;
    logic [3:0]  r_fcnt, n_fcnt;
    logic [10:0] r_off, n_off;
    logic        r_halt, n_halt;

    logic        bit_in;
    logic        eob;
    logic [10:0] fs;
    logic [3:0]  fc;
    logic [3:0]  fwidth;
    logic [2:0]  kind;
    logic [10:0] cdata;
    logic [4:0]  clen;
    logic        need_push;
    logic        advance;
    logic        accept;

    always_comb begin
        bit_in  = r_sh[7];
        eob     = (r_bitn == 3'd7);
        fs      = {r_field[9:0], bit_in};
        fc      = r_fcnt + 4'd1;
        n_phase = r_phase;
        n_field = r_field;
        n_fcnt  = r_fcnt;
        n_off   = r_off;
        n_halt  = r_halt;
        kind    = lzs_pkg::CMD_MARK;
        cdata   = '0;
        clen    = '0;
        case (r_phase)
            PH_LIT:   fwidth = 4'd8;
            PH_SHORT: fwidth = 4'd7;
            PH_LONG:  fwidth = 4'd11;
            PH_LEN_A: fwidth = 4'd2;
            PH_LEN_B: fwidth = 4'd2;
            default:  fwidth = 4'd4;
        endcase
        if (!r_halt) begin
            if (r_phase == PH_FLAG) begin
                n_phase = bit_in ? PH_TYPE : PH_LIT;
                n_field = '0;
                n_fcnt  = '0;
            end else if (r_phase == PH_TYPE) begin
                n_phase = bit_in ? PH_SHORT : PH_LONG;
                n_field = '0;
                n_fcnt  = '0;
            end else if (fc < fwidth) begin
                n_field = fs;
                n_fcnt  = fc;
            end else begin
                n_field = '0;
                n_fcnt  = '0;
                n_phase = PH_FLAG;
                case (r_phase)
                    PH_LIT: begin
                        kind  = lzs_pkg::CMD_LIT;
                        cdata = {3'b000, fs[7:0]};
                    end
                    PH_SHORT, PH_LONG: begin
                        if (fs == 11'd0) begin
                            kind   = (r_phase == PH_SHORT) ? lzs_pkg::CMD_END
                                                           : lzs_pkg::CMD_ERR;
                            n_halt = 1'b1;
                        end else begin
                            n_off   = fs;
                            n_phase = PH_LEN_A;
                        end
                    end
                    PH_LEN_A: begin
                        if (fs[1:0] == 2'd3) begin
                            n_phase = PH_LEN_B;
                        end else begin
                            kind  = lzs_pkg::CMD_COPY;
                            cdata = r_off;
                            clen  = {3'b000, fs[1:0]} + 5'd2;
                        end
                    end
                    PH_LEN_B: begin
                        if (fs[1:0] == 2'd3) begin
                            n_phase = PH_NIB;
                        end else begin
                            kind  = lzs_pkg::CMD_COPY;
                            cdata = r_off;
                            clen  = {3'b000, fs[1:0]} + 5'd5;
                        end
                    end
                    default: begin
                        kind  = lzs_pkg::CMD_COPY;
                        cdata = r_off;
                        if (fs[3:0] == 4'hF) begin
                            clen    = 5'd15;
                            n_phase = PH_NIB;
                        end else begin
                            clen = {1'b0, fs[3:0]} + 5'd8;
                        end
                    end
                endcase
            end
        end
    end

    assign need_push     = r_busy && ((kind != lzs_pkg::CMD_MARK) || eob);
    assign o_push        = need_push && !i_full;
    assign advance       = r_busy && !(need_push && i_full);
    assign o_ready       = !r_busy || (advance && eob);
    assign accept        = i_valid && o_ready;
    assign o_cmd.kind    = kind;
    assign o_cmd.restart = r_restart;
    assign o_cmd.eob     = eob;
    assign o_cmd.data    = cdata;
    assign o_cmd.len     = clen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_bitn    <= '0;
            r_restart <= 1'b0;
            r_phase   <= PH_FLAG;
            r_field   <= '0;
            r_fcnt    <= '0;
            r_off     <= '0;
            r_halt    <= 1'b0;
        end else if (accept) begin
            r_busy    <= 1'b1;
            r_bitn    <= '0;
            r_restart <= i_new_stream;
            if (i_new_stream) begin
                r_phase <= PH_FLAG;
                r_field <= '0;
                r_fcnt  <= '0;
                r_off   <= '0;
                r_halt  <= 1'b0;
            end else if (advance) begin
                r_phase <= n_phase;
                r_field <= n_field;
                r_fcnt  <= n_fcnt;
                r_off   <= n_off;
                r_halt  <= n_halt;
            end
        end else if (advance) begin
            r_phase <= n_phase;
            r_field <= n_field;
            r_fcnt  <= n_fcnt;
            r_off   <= n_off;
            r_halt  <= n_halt;
            r_bitn  <= r_bitn + 3'd1;
            if (o_push) begin
                r_restart <= 1'b0;
            end
            if (eob) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sh <= i_compressed_byte;
        end else if (advance) begin
            r_sh <= {r_sh[6:0], 1'b0};
        end
    end

endmodule

// ----- rtl/lzs_fifo.sv -----
module lzs_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lzs_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output lzs_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    lzs_pkg::t_cmd                r_mem [lzs_pkg::Q_DEPTH];
    logic [lzs_pkg::Q_AW-1:0]     r_wp;
    logic [lzs_pkg::Q_AW-1:0]     r_rp;
    logic [lzs_pkg::Q_AW:0]       r_cnt;

    assign o_full  = (r_cnt == (lzs_pkg::Q_AW + 1)'(lzs_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ----- rtl/lzs_back.sv -----
module lzs_back #(
    parameter int DEPTH = 2048
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lzs_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_last_of_run,
    output logic          o_stream_end,
    output logic          o_format_error
);

    localparam int AW = $clog2(DEPTH);
    localparam int HW = AW + 1;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_EXEC = 3'd1;
    localparam logic [2:0] B_RD   = 3'd2;
    localparam logic [2:0] B_WR   = 3'd3;
    localparam logic [2:0] B_FIN  = 3'd4;

    logic [7:0]                r_hist [DEPTH];
    logic [2:0]                r_state, n_state;
    lzs_pkg::t_cmd             r_cmd;
    logic [AW-1:0]             r_wp;
    logic [HW-1:0]             r_hwm;
    logic [lzs_pkg::LEN_W-1:0] r_left;
    logic [7:0]                r_rdata;
    logic                      r_rd_ok;
    logic                      r_pv;
    logic [7:0]                r_pbyte;
    logic                      r_pend;
    logic                      r_perr;
    logic                      r_ov;
    logic [7:0]                r_obyte;
    logic                      r_olast;
    logic                      r_oend;
    logic                      r_oerr;

    logic          sink_free;
    logic          can_prod;
    logic          prod;
    logic [7:0]    prod_byte;
    logic          prod_end;
    logic          prod_err;
    logic          fin;
    logic          we;
    logic [7:0]    wdata;
    logic [AW-1:0] off_ext;
    logic [AW:0]   src_wrap;
    logic [AW-1:0] src;
    logic [AW-1:0] wp_next;
    logic [HW-1:0] wp_inc;
    logic [7:0]    rbyte;
    logic [2:0]    done_state;

    assign sink_free  = !r_ov || i_ready;
    assign can_prod   = !r_pv || sink_free;
    assign off_ext    = AW'(r_cmd.data);
    assign src_wrap   = {1'b0, r_wp} + (AW + 1)'(DEPTH) - {1'b0, off_ext};
    assign src        = (r_wp >= off_ext) ? (r_wp - off_ext) : src_wrap[AW-1:0];
    assign wp_next    = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign wp_inc     = {1'b0, r_wp} + 1'b1;
    assign rbyte      = r_rd_ok ? r_rdata : 8'h00;
    assign done_state = r_cmd.eob ? B_FIN : B_IDLE;

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        we        = 1'b0;
        wdata     = rbyte;
        prod      = 1'b0;
        prod_byte = 8'h00;
        prod_end  = 1'b0;
        prod_err  = 1'b0;
        fin       = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = B_EXEC;
                end
            end
            B_EXEC: begin
                case (r_cmd.kind)
                    lzs_pkg::CMD_LIT: begin
                        if (can_prod) begin
                            we        = 1'b1;
                            wdata     = r_cmd.data[7:0];
                            prod      = 1'b1;
                            prod_byte = r_cmd.data[7:0];
                            n_state   = done_state;
                        end
                    end
                    lzs_pkg::CMD_END: begin
                        if (can_prod) begin
                            prod     = 1'b1;
                            prod_end = 1'b1;
                            n_state  = done_state;
                        end
                    end
                    lzs_pkg::CMD_ERR: begin
                        if (can_prod) begin
                            prod     = 1'b1;
                            prod_err = 1'b1;
                            n_state  = done_state;
                        end
                    end
                    lzs_pkg::CMD_COPY: begin
                        n_state = B_RD;
                    end
                    default: begin
                        n_state = done_state;
                    end
                endcase
            end
            B_RD: begin
                n_state = B_WR;
            end
            B_WR: begin
                if (can_prod) begin
                    we        = 1'b1;
                    prod      = 1'b1;
                    prod_byte = rbyte;
                    n_state   = (r_left == 5'd1) ? done_state : B_RD;
                end
            end
            B_FIN: begin
                if (!r_pv) begin
                    n_state = B_IDLE;
                end else if (sink_free) begin
                    fin     = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_wp    <= '0;
            r_hwm   <= '0;
            r_left  <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_left <= i_cmd.len;
                if (i_cmd.restart) begin
                    r_wp <= '0;
                end
            end
            if (we) begin
                r_wp <= wp_next;
                if (wp_inc > r_hwm) begin
                    r_hwm <= wp_inc;
                end
            end
            if (r_state == B_WR && can_prod) begin
                r_left <= r_left - 1'b1;
            end
            if (prod) begin
                r_pv <= 1'b1;
            end else if (fin) begin
                r_pv <= 1'b0;
            end
            if ((prod && r_pv) || fin) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (prod) begin
            r_pbyte <= prod_byte;
            r_pend  <= prod_end;
            r_perr  <= prod_err;
        end
        if ((prod && r_pv) || fin) begin
            r_obyte <= r_pbyte;
            r_oend  <= r_pend;
            r_oerr  <= r_perr;
            r_olast <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_hist[r_wp] <= wdata;
        end
        if (r_state == B_RD) begin
            r_rdata <= r_hist[src];
            r_rd_ok <= ({1'b0, src} < r_hwm);
        end
    end

    assign o_valid        = r_ov;
    assign o_out_byte     = r_obyte;
    assign o_last_of_run  = r_olast;
    assign o_stream_end   = r_oend;
    assign o_format_error = r_oerr;

    a_hwm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hwm <= HW'(DEPTH))
        else $error("history high-water mark past depth");

    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_WR |-> $past(r_state) == B_RD || $past(r_state) == B_WR)
        else $error("copy write without read");

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_RD || r_state == B_WR) |-> r_left != '0)
        else $error("copy with zero bytes left");

    a_fin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> o_valid && o_last_of_run)
        else $error("closing result not flagged last");

endmodule

// ----- rtl/lzs_stream_decompressor.sv -----
// channel  | handshake          | payload
// ---------+--------------------+----------------------------------------------
// input    | i_valid / o_ready  | i_new_stream, i_compressed_byte
// output   | o_valid / i_ready  | o_out_byte, o_last_of_run, o_stream_end,
//          |                    | o_format_error
//
// Parser consumes one stream bit per cycle, stalling while the command queue is full.
// Each copied byte passes through a history read state, then a write-and-emit state.
// A 4-entry command queue separates parser and copy engine; parser stalls while full.
// History holds no clearing pass: a high-water mark makes entries not written since reset read 0.
// Reset: i_rst_n synchronous, active low.
module lzs_stream_decompressor #(
    parameter int HISTORY_DEPTH = 2048
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_new_stream,
    input  logic [7:0] i_compressed_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_stream_end,
    output logic       o_format_error
);

    logic          push;
    logic          full;
    logic          pop;
    logic          empty;
    lzs_pkg::t_cmd cmd_in;
    lzs_pkg::t_cmd cmd_out;

    lzs_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_new_stream      (i_new_stream),
        .i_compressed_byte (i_compressed_byte),
        .o_push            (push),
        .o_cmd             (cmd_in),
        .i_full            (full)
    );

    lzs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_empty (empty)
    );

    lzs_back #(
        .DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd_out),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_last_of_run  (o_last_of_run),
        .o_stream_end   (o_stream_end),
        .o_format_error (o_format_error)
    );

endmodule

// ----- tb/lzs_decode_checker.sv -----
module lzs_decode_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_new_stream,
    input  logic [7:0] i_compressed_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_last_of_run,
    input  logic       i_stream_end,
    input  logic       i_format_error,
    output int         o_fail_count,
    output int         o_pending
);

    typedef enum logic [3:0] {
        ST_FLAG,
        ST_TYPE,
        ST_LIT,
        ST_SHORT,
        ST_LONG,
        ST_LEN_A,
        ST_LEN_B,
        ST_NIB
    } t_parse_state;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       stream_end;
        logic       format_error;
    } t_decoded_result;

    logic [7:0]        history [0:2047];
    logic [10:0]       hist_wr_ptr;
    logic [10:0]       field_bits;
    logic [3:0]        field_count;
    logic [10:0]       copy_offset;
    t_parse_state      state;
    logic              halted;
    t_decoded_result   decoded_q[$];
    int                fail_total = 0;

    task automatic enter_field(input t_parse_state next_state);
        state = next_state;
        field_bits = '0;
        field_count = '0;
    endtask

    task automatic add_result(input logic [7:0] data, input logic at_end, input logic bad);
        t_decoded_result r;
        r.data = data;
        r.last = 1'b0;
        r.stream_end = at_end;
        r.format_error = bad;
        decoded_q = {decoded_q, r};
    endtask

    task automatic store_byte(input logic [7:0] data);
        history[hist_wr_ptr] = data;
        hist_wr_ptr = hist_wr_ptr + 11'd1;
        add_result(data, 1'b0, 1'b0);
    endtask

    // byte-by-byte so an overlapping copy sees its own output
    task automatic copy_bytes(input int unsigned count);
        logic [10:0] src;
        for (int unsigned n = 0; n < count; n++) begin
            src = hist_wr_ptr - copy_offset;
            store_byte(history[src]);
        end
    endtask

    task automatic parse_bit(input logic b);
        int unsigned width;
        logic [10:0] v;
        if (halted) return;
        if (state == ST_FLAG) begin
            enter_field(b ? ST_TYPE : ST_LIT);
            return;
        end
        if (state == ST_TYPE) begin
            enter_field(b ? ST_SHORT : ST_LONG);
            return;
        end
        field_bits = {field_bits[9:0], b};
        field_count = field_count + 4'd1;
        case (state)
            ST_LIT: width = 8;
            ST_SHORT: width = 7;
            ST_LONG: width = 11;
            ST_LEN_A, ST_LEN_B: width = 2;
            default: width = 4;
        endcase
        if (field_count < width) return;
        v = field_bits;
        case (state)
            ST_LIT: begin
                store_byte(v[7:0]);
                enter_field(ST_FLAG);
            end
            ST_SHORT, ST_LONG: begin
                if (v == 11'd0) begin
                    add_result(8'h00, state == ST_SHORT, state == ST_LONG);
                    halted = 1'b1;
                    enter_field(ST_FLAG);
                end else begin
                    copy_offset = v;
                    enter_field(ST_LEN_A);
                end
            end
            ST_LEN_A: begin
                if (v == 11'd3) begin
                    enter_field(ST_LEN_B);
                end else begin
                    copy_bytes(v + 2);
                    enter_field(ST_FLAG);
                end
            end
            ST_LEN_B: begin
                if (v == 11'd3) begin
                    enter_field(ST_NIB);
                end else begin
                    copy_bytes(v + 5);
                    enter_field(ST_FLAG);
                end
            end
            default: begin
                if (v == 11'd15) begin
                    copy_bytes(15);
                    enter_field(ST_NIB);
                end else begin
                    copy_bytes(v + 8);
                    enter_field(ST_FLAG);
                end
            end
        endcase
    endtask

    task automatic decode_item(input logic new_stream, input logic [7:0] data);
        int unsigned first_new;
        if (new_stream) begin
            enter_field(ST_FLAG);
            hist_wr_ptr = '0;
            copy_offset = '0;
            halted = 1'b0;
        end
        first_new = decoded_q.size();
        for (int i = 7; i >= 0; i--) parse_bit(data[i]);
        if (decoded_q.size() > first_new) decoded_q[decoded_q.size() - 1].last = 1'b1;
    endtask

    always @(posedge i_clk) begin : watch
        t_decoded_result want;
        t_decoded_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < 2048; i++) history[i] = 8'h00;
            hist_wr_ptr = '0;
            copy_offset = '0;
            halted = 1'b0;
            enter_field(ST_FLAG);
            decoded_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) decode_item(i_new_stream, i_compressed_byte);
            if (i_out_valid && i_out_ready) begin
                got = {i_out_byte, i_last_of_run, i_stream_end, i_format_error};
                if (decoded_q.size() == 0) begin
                    if (fail_total < 10)
                        $display("%0t: unexpected result byte %02h last %0b end %0b err %0b",
                                 $time, got.data, got.last, got.stream_end, got.format_error);
                    fail_total++;
                end else begin
                    want = decoded_q.pop_front();
                    if (got != want) begin
                        if (fail_total < 10)
                            $display("%0t: want %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                                     $time, want.data, want.last, want.stream_end,
                                     want.format_error, got.data, got.last,
                                     got.stream_end, got.format_error);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending <= decoded_q.size();
    end

endmodule

// ----- tb/tb_lzs_stream_decompressor.sv -----
module tb_lzs_stream_decompressor;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       i_new_stream = 1'b0;
    logic [7:0] i_compressed_byte = 8'h00;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;
    logic       o_stream_end;
    logic       o_format_error;
    int         fail_count;
    int         pending;

    int         send_idle_pct = 0;
    int         ready_stall_pct = 0;
    int         items_sent = 0;
    bit         stream_bits[$];
    int         decoded_len;

    lzs_stream_decompressor DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_new_stream     (i_new_stream),
        .i_compressed_byte(i_compressed_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_byte       (o_out_byte),
        .o_last_of_run    (o_last_of_run),
        .o_stream_end     (o_stream_end),
        .o_format_error   (o_format_error)
    );

    lzs_decode_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_new_stream     (i_new_stream),
        .i_compressed_byte(i_compressed_byte),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_out_byte       (o_out_byte),
        .i_last_of_run    (o_last_of_run),
        .i_stream_end     (o_stream_end),
        .i_format_error   (o_format_error),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99, 0) >= ready_stall_pct);
    end

    // called at a rising edge, returns at the edge that accepts the item
    task automatic send_item(input logic new_stream, input logic [7:0] data);
        bit taken;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_new_stream <= new_stream;
        i_compressed_byte <= data;
        do begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end while (!taken);
        items_sent++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic put_bits(input int unsigned value, input int nbits);
        for (int i = nbits - 1; i >= 0; i--) stream_bits = {stream_bits, value[i]};
    endtask

    task automatic put_literal(input logic [7:0] data);
        put_bits(0, 1);
        put_bits(data, 8);
    endtask

    task automatic put_match(input int unsigned offset, input int unsigned len,
                             input bit long_off);
        int unsigned rest;
        put_bits(1, 1);
        if (long_off) begin
            put_bits(0, 1);
            put_bits(offset, 11);
        end else begin
            put_bits(1, 1);
            put_bits(offset, 7);
        end
        if (len <= 4) begin
            put_bits(len - 2, 2);
        end else if (len <= 7) begin
            put_bits(3, 2);
            put_bits(len - 5, 2);
        end else begin
            put_bits(15, 4);
            rest = len - 8;
            while (rest >= 15) begin
                put_bits(15, 4);
                rest -= 15;
            end
            put_bits(rest, 4);
        end
    endtask

    task automatic put_end_marker();
        put_bits(1, 1);
        put_bits(1, 1);
        put_bits(0, 7);
    endtask

    task automatic put_bad_offset();
        put_bits(1, 1);
        put_bits(0, 1);
        put_bits(0, 11);
    endtask

    // pad to a whole byte and send, new_stream on the first byte
    task automatic flush_stream();
        logic [7:0] data;
        while (stream_bits.size() % 8 != 0)
            stream_bits = {stream_bits, 1'($urandom_range(1, 0))};
        for (int i = 0; i < stream_bits.size(); i += 8) begin
            for (int j = 0; j < 8; j++) data = {data[6:0], stream_bits[i + j]};
            send_item(i == 0, data);
        end
        stream_bits.delete();
    endtask

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 40) return 2 + $urandom_range(2, 0);
        if (r < 65) return 5 + $urandom_range(2, 0);
        if (r < 85) return 8 + $urandom_range(14, 0);
        return 8 + $urandom_range(90, 15);
    endfunction

    task automatic gen_stream(input int tokens);
        int unsigned offset;
        int unsigned span;
        int unsigned len;
        bit long_off;
        int unsigned r;
        decoded_len = 0;
        for (int k = 0; k < tokens; k++) begin
            if (decoded_len == 0 || $urandom_range(99, 0) < 40) begin
                put_literal(8'($urandom_range(255, 0)));
                decoded_len++;
            end else begin
                long_off = 1'($urandom_range(1, 0));
                span = long_off ? 2047 : 127;
                if (decoded_len < span) span = decoded_len;
                if ($urandom_range(99, 0) < 10)
                    offset = $urandom_range(long_off ? 2047 : 127, 1);
                else
                    offset = $urandom_range(span, 1);
                len = pick_len();
                put_match(offset, len, long_off);
                decoded_len += len;
            end
        end
        r = $urandom_range(99, 0);
        if (r < 80) put_end_marker();
        else if (r < 90) put_bad_offset();
        flush_stream();
    endtask

    initial begin
        int goal;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // literals at the extremes, all two-bit length codes, nibble lengths, overlap, far offsets, end marker
        put_literal(8'h00);
        put_literal(8'hFF);
        put_match(1, 2, 1'b0);
        put_match(3, 3, 1'b1);
        put_match(127, 4, 1'b0);
        put_match(2047, 5, 1'b1);
        put_match(2, 6, 1'b0);
        put_match(1, 7, 1'b0);
        put_match(4, 8, 1'b0);
        put_match(5, 37, 1'b1);
        put_end_marker();
        flush_stream();
        send_item(1'b0, 8'hFF);
        // long offset of zero halts decoding
        put_literal(8'h5A);
        put_bad_offset();
        flush_stream();
        send_item(1'b0, 8'h81);

        goal = items_sent;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    ready_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 53;
                    ready_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    ready_stall_pct = 53;
                    i_valid <= 1'b0;
                    wait_drained();
                end
                default: begin
                    send_idle_pct = 7;
                    ready_stall_pct = 7;
                end
            endcase
            goal += 75;
            while (items_sent < goal) begin
                if ($urandom_range(99, 0) < 10) begin
                    send_item(1'b1, 8'($urandom_range(255, 0)));
                    repeat ($urandom_range(3, 1)) send_item(1'b0, 8'($urandom_range(255, 0)));
                end else begin
                    gen_stream($urandom_range(30, 3));
                end
            end
        end
        i_valid <= 1'b0;
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_lzs_stream_decompressor: done, clean");
        else
            $display("tb_lzs_stream_decompressor: done, errors");
        $finish;
    end

    initial begin
        #40000000;
        $display("tb_lzs_stream_decompressor: done, errors");
        $finish;
    end

endmodule
